// File: hdl/edge_avoid_drive_sequencer_macros.svh
// Assertion macros used by the edge-avoiding drive sequencer core (eads_core).
`ifndef EDGE_AVOID_DRIVE_SEQUENCER_MACROS_SVH
`define EDGE_AVOID_DRIVE_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define EADS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sequencer check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define EADS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sequencer check failed");
`else
`define EADS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define EADS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/eads_pkg.sv
// Types, constants and phase step functions of the edge-avoiding drive sequencer.
package eads_pkg;

	localparam int SAMPLE_W = 10;
	localparam int THRESH_W = 10;
	localparam int PAUSE_W  = 8;
	localparam int CMP_W    = 8;
	localparam int TICK_W   = PAUSE_W + 1;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	typedef enum logic [2:0] {
		PH_CRUISE    = 3'd0,
		PH_STOP      = 3'd1,
		PH_SPIN_R    = 3'd2,
		PH_SPIN_L    = 3'd3,
		PH_STOP_BOTH = 3'd4,
		PH_BACK      = 3'd5,
		PH_FINAL_R   = 3'd6
	} phase_t;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_THRESHOLD    = 2'd0;
	localparam reg_idx_t REG_PAUSE        = 2'd1;
	localparam reg_idx_t REG_LEFT_CENTER  = 2'd2;
	localparam reg_idx_t REG_RIGHT_CENTER = 2'd3;

	localparam logic [THRESH_W-1:0] RST_THRESHOLD    = 10'd50;
	localparam logic [PAUSE_W-1:0]  RST_PAUSE        = 8'd36;
	localparam logic [CMP_W-1:0]    RST_LEFT_CENTER  = 8'd27;
	localparam logic [CMP_W-1:0]    RST_RIGHT_CENTER = 8'd28;

	typedef struct packed {
		logic [THRESH_W-1:0] threshold;
		logic [PAUSE_W-1:0]  pause;
		logic [CMP_W-1:0]    left_center;
		logic [CMP_W-1:0]    right_center;
	} cfg_t;

	typedef struct packed {
		logic             l_en;
		logic [CMP_W-1:0] l_cmp;
		logic             r_en;
		logic [CMP_W-1:0] r_cmp;
	} drive_t;

	typedef struct packed {
		phase_t             ph;
		logic               spin_left;
		logic [TICK_W-1:0]  dur;
	} hop_t;

	typedef struct packed {
		drive_t drive;
		logic   left_edge;
		logic   right_edge;
		phase_t ph;
	} result_t;

	// Next phase and its length once the current phase has run out.
	function automatic hop_t advance_phase(phase_t ph, logic spin_left, logic lf, logic rf,
			logic [PAUSE_W-1:0] pause);
		hop_t h;
		logic [TICK_W-1:0] p0;
		logic [TICK_W-1:0] p1;
		p0 = {1'b0, pause};
		p1 = p0 + TICK_W'(1);
		h.spin_left = spin_left;
		unique case (ph)
			PH_STOP: begin
				h.ph  = spin_left ? PH_SPIN_L : PH_SPIN_R;
				h.dur = p1;
			end
			PH_STOP_BOTH: begin
				h.ph  = PH_BACK;
				h.dur = p0;
			end
			PH_BACK: begin
				h.ph  = PH_FINAL_R;
				h.dur = p1;
			end
			default: begin
				// end of a maneuver or cruise: decide from this tick's flags
				priority if (!lf && !rf) begin
					h.ph  = PH_CRUISE;
					h.dur = TICK_W'(1);
				end else if (lf && rf) begin
					h.ph  = PH_STOP_BOTH;
					h.dur = p0;
				end else begin
					h.ph        = PH_STOP;
					h.spin_left = rf;
					h.dur       = p0;
				end
			end
		endcase
		return h;
	endfunction

	// Wheel outputs on entry to a phase; a stopped wheel keeps its compare value.
	function automatic drive_t enter_drive(phase_t ph, drive_t d, logic [CMP_W-1:0] lc,
			logic [CMP_W-1:0] rc);
		drive_t n;
		n = d;
		unique case (ph)
			PH_CRUISE: begin
				n.l_en  = 1'b1;
				n.l_cmp = lc + CMP_W'(1);
				n.r_en  = 1'b1;
				n.r_cmp = rc - CMP_W'(1);
			end
			PH_SPIN_R: begin
				n.l_en  = 1'b0;
				n.r_en  = 1'b1;
				n.r_cmp = rc + CMP_W'(2);
			end
			PH_SPIN_L: begin
				n.l_en  = 1'b1;
				n.l_cmp = lc - CMP_W'(2);
				n.r_en  = 1'b0;
			end
			PH_BACK: begin
				n.l_en  = 1'b1;
				n.l_cmp = lc - CMP_W'(1);
				n.r_en  = 1'b1;
				n.r_cmp = rc + CMP_W'(1);
			end
			default: begin
				n.l_en = 1'b0;
				n.r_en = 1'b0;
			end
		endcase
		return n;
	endfunction

endpackage

// File: hdl/eads_regs.sv
// APB register file holding the threshold, pause length and servo centers.
module eads_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [eads_pkg::ADDR_W-1:0] paddr,
	input  logic [eads_pkg::DATA_W-1:0] pwdata,
	output logic [eads_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output eads_pkg::cfg_t              cfg
);
	import eads_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= RST_THRESHOLD;
			cfg_q.pause        <= RST_PAUSE;
			cfg_q.left_center  <= RST_LEFT_CENTER;
			cfg_q.right_center <= RST_RIGHT_CENTER;
		end else if (wr_en) begin
			unique case (idx)
				REG_THRESHOLD:    cfg_q.threshold    <= pwdata[THRESH_W-1:0];
				REG_PAUSE:        cfg_q.pause        <= pwdata[PAUSE_W-1:0];
				REG_LEFT_CENTER:  cfg_q.left_center  <= pwdata[CMP_W-1:0];
				REG_RIGHT_CENTER: cfg_q.right_center <= pwdata[CMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_THRESHOLD:    prdata = DATA_W'(cfg_q.threshold);
			REG_PAUSE:        prdata = DATA_W'(cfg_q.pause);
			REG_LEFT_CENTER:  prdata = DATA_W'(cfg_q.left_center);
			REG_RIGHT_CENTER: prdata = DATA_W'(cfg_q.right_center);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: hdl/eads_core.sv
// Chasm detection and maneuver sequencer state, updated once per accepted tick.
`include "edge_avoid_drive_sequencer_macros.svh"
module eads_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  eads_pkg::cfg_t                cfg,
	input  logic                          en,
	input  logic [eads_pkg::SAMPLE_W-1:0] left_dark,
	input  logic [eads_pkg::SAMPLE_W-1:0] left_lit,
	input  logic [eads_pkg::SAMPLE_W-1:0] right_dark,
	input  logic [eads_pkg::SAMPLE_W-1:0] right_lit,
	output eads_pkg::result_t             res
);
	import eads_pkg::*;

	phase_t            ph_q;
	logic              spin_left_q;
	logic [TICK_W-1:0] ticks_q;
	drive_t            drv_q;

	logic              lf;
	logic              rf;
	logic [TICK_W-1:0] t_left;
	hop_t              hop1;
	hop_t              hop2;
	hop_t              hop3;
	drive_t            drv1;
	drive_t            drv2;
	drive_t            drv3;
	phase_t            ph_nxt;
	logic              spin_left_nxt;
	logic [TICK_W-1:0] ticks_nxt;
	drive_t            drv_nxt;

	// floor is present when the lit reading is lower by more than the threshold or lies above the dark reading
	assign lf = (left_dark >= left_lit) && ((left_dark - left_lit) <= cfg.threshold);
	assign rf = (right_dark >= right_lit) && ((right_dark - right_lit) <= cfg.threshold);

	always_comb begin
		if ((ph_q > PH_FINAL_R) || (ticks_q == '0)) begin
			t_left = '0;
		end else begin
			t_left = ticks_q - TICK_W'(1);
		end

		// zero-length phases fall through to the next one in the same tick
		hop1 = advance_phase(ph_q, spin_left_q, lf, rf, cfg.pause);
		drv1 = enter_drive(hop1.ph, drv_q, cfg.left_center, cfg.right_center);
		hop2 = advance_phase(hop1.ph, hop1.spin_left, lf, rf, cfg.pause);
		drv2 = enter_drive(hop2.ph, drv1, cfg.left_center, cfg.right_center);
		hop3 = advance_phase(hop2.ph, hop2.spin_left, lf, rf, cfg.pause);
		drv3 = enter_drive(hop3.ph, drv2, cfg.left_center, cfg.right_center);

		priority if (t_left != '0) begin
			ph_nxt        = ph_q;
			spin_left_nxt = spin_left_q;
			ticks_nxt     = t_left;
			drv_nxt       = drv_q;
		end else if (hop1.dur != '0) begin
			ph_nxt        = hop1.ph;
			spin_left_nxt = hop1.spin_left;
			ticks_nxt     = hop1.dur;
			drv_nxt       = drv1;
		end else if (hop2.dur != '0) begin
			ph_nxt        = hop2.ph;
			spin_left_nxt = hop2.spin_left;
			ticks_nxt     = hop2.dur;
			drv_nxt       = drv2;
		end else begin
			ph_nxt        = hop3.ph;
			spin_left_nxt = hop3.spin_left;
			ticks_nxt     = hop3.dur;
			drv_nxt       = drv3;
		end

		res.drive      = drv_nxt;
		res.left_edge  = lf;
		res.right_edge = rf;
		res.ph         = ph_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_CRUISE;
			spin_left_q <= 1'b0;
			ticks_q     <= TICK_W'(1);
			drv_q.l_en  <= 1'b1;
			drv_q.l_cmp <= RST_LEFT_CENTER + CMP_W'(1);
			drv_q.r_en  <= 1'b1;
			drv_q.r_cmp <= RST_RIGHT_CENTER - CMP_W'(1);
		end else if (en) begin
			ph_q        <= ph_nxt;
			spin_left_q <= spin_left_nxt;
			ticks_q     <= ticks_nxt;
			drv_q       <= drv_nxt;
		end
	end

	`EADS_ASSERT_NOW(a_ticks_live, clk, arst_n, 1'b1, ticks_q != '0)
	`EADS_ASSERT_NEXT(a_phase_holds, clk, arst_n, en && (t_left != '0), $stable(ph_q))
	`EADS_ASSERT_NOW(a_cruise_drives, clk, arst_n, ph_q == PH_CRUISE, drv_q.l_en && drv_q.r_en)
	`EADS_ASSERT_NOW(a_stop_idles, clk, arst_n, (ph_q == PH_STOP) || (ph_q == PH_STOP_BOTH),
		!drv_q.l_en && !drv_q.r_en)

endmodule

// File: hdl/edge_avoid_drive_sequencer.sv
// Edge-avoiding drive sequencer: one tick of sensor readings in, one servo command out.
// Each accepted tick is registered and evaluated combinationally by the chasm compare
// and the phase sequencer; its result is loaded into the output register, raising
// out_valid, whenever that register is empty or being emptied. One tick is accepted per
// cycle while out_stall does not hold a finished result. The result register decouples
// the two sides, so a new tick is taken while a finished result waits. Registers
// (APB, byte address 4*i): 0 detect threshold, 1 pause ticks, 2 left center, 3 right center;
// write them only while no tick is in flight.
module edge_avoid_drive_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [eads_pkg::ADDR_W-1:0]   paddr,
	input  logic [eads_pkg::DATA_W-1:0]   pwdata,
	output logic [eads_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [eads_pkg::SAMPLE_W-1:0] left_dark,
	input  logic [eads_pkg::SAMPLE_W-1:0] left_lit,
	input  logic [eads_pkg::SAMPLE_W-1:0] right_dark,
	input  logic [eads_pkg::SAMPLE_W-1:0] right_lit,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          left_enable,
	output logic [eads_pkg::CMP_W-1:0]    left_compare,
	output logic                          right_enable,
	output logic [eads_pkg::CMP_W-1:0]    right_compare,
	output logic                          left_edge,
	output logic                          right_edge,
	output logic [2:0]                    phase_now
);
	import eads_pkg::*;

	cfg_t                cfg;
	result_t             res;
	result_t             res_s2;
	logic                vld_s1;
	logic                vld_s2;
	logic [SAMPLE_W-1:0] left_dark_s1;
	logic [SAMPLE_W-1:0] left_lit_s1;
	logic [SAMPLE_W-1:0] right_dark_s1;
	logic [SAMPLE_W-1:0] right_lit_s1;
	logic                in_acc;
	logic                take_s2;

	eads_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	eads_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.en         (take_s2),
		.left_dark  (left_dark_s1),
		.left_lit   (left_lit_s1),
		.right_dark (right_dark_s1),
		.right_lit  (right_lit_s1),
		.res        (res)
	);

	// advance the registered tick when the result register is free or being emptied
	assign take_s2  = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && !take_s2;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				vld_s1 <= 1'b1;
			end else if (take_s2) begin
				vld_s1 <= 1'b0;
			end
			if (take_s2) begin
				vld_s2 <= 1'b1;
			end else if (!out_stall) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			left_dark_s1  <= left_dark;
			left_lit_s1   <= left_lit;
			right_dark_s1 <= right_dark;
			right_lit_s1  <= right_lit;
		end
		if (take_s2) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = vld_s2;
	assign left_enable   = res_s2.drive.l_en;
	assign left_compare  = res_s2.drive.l_cmp;
	assign right_enable  = res_s2.drive.r_en;
	assign right_compare = res_s2.drive.r_cmp;
	assign left_edge     = res_s2.left_edge;
	assign right_edge    = res_s2.right_edge;
	assign phase_now     = res_s2.ph;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the edge-avoiding drive sequencer.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import eads_pkg::*;

	typedef enum {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		reg_idx_t            idx;
		logic [DATA_W-1:0]   value;
		logic [SAMPLE_W-1:0] ld;
		logic [SAMPLE_W-1:0] ll;
		logic [SAMPLE_W-1:0] rd;
		logic [SAMPLE_W-1:0] rl;
		bit                  typed;
		result_t             want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [SAMPLE_W-1:0] left_dark = '0;
	logic [SAMPLE_W-1:0] left_lit = '0;
	logic [SAMPLE_W-1:0] right_dark = '0;
	logic [SAMPLE_W-1:0] right_lit = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                left_enable;
	logic [CMP_W-1:0]    left_compare;
	logic                right_enable;
	logic [CMP_W-1:0]    right_compare;
	logic                left_edge;
	logic                right_edge;
	logic [2:0]          phase_now;

	edge_avoid_drive_sequencer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.left_dark    (left_dark),
		.left_lit     (left_lit),
		.right_dark   (right_dark),
		.right_lit    (right_lit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.left_enable  (left_enable),
		.left_compare (left_compare),
		.right_enable (right_enable),
		.right_compare(right_compare),
		.left_edge    (left_edge),
		.right_edge   (right_edge),
		.phase_now    (phase_now)
	);

	always #4 clk = ~clk;

	// steering model state
	cfg_t              cfg_now;
	phase_t            st_phase;
	logic [TICK_W-1:0] st_left;
	logic              st_spin_left;
	logic              st_lf;
	logic              st_rf;
	drive_t            st_drive;

	result_t   pending_steer[$];
	int        mismatches = 0;
	bit        valid_held = 1'b0;
	bit        tx_quiet = 1'b0;
	bit        rx_quiet = 1'b0;
	int        stall_run = 0;
	plan_row_t plan[$];

	function automatic void set_wheels(int ls, int rs);
		if (ls != 0) begin
			st_drive.l_cmp = cfg_now.left_center + CMP_W'(ls);
			st_drive.l_en  = 1'b1;
		end else begin
			st_drive.l_en = 1'b0;
		end
		if (rs != 0) begin
			st_drive.r_cmp = cfg_now.right_center - CMP_W'(rs);
			st_drive.r_en  = 1'b1;
		end else begin
			st_drive.r_en = 1'b0;
		end
	endfunction

	function automatic void enter_phase(phase_t p, logic [TICK_W-1:0] n);
		st_phase = p;
		st_left  = n;
		case (p)
			PH_CRUISE: set_wheels(1, 1);
			PH_SPIN_R: set_wheels(0, -2);
			PH_SPIN_L: set_wheels(-2, 0);
			PH_BACK:   set_wheels(-1, -1);
			default:   set_wheels(0, 0);
		endcase
	endfunction

	function automatic void next_phase();
		logic [TICK_W-1:0] p0;
		p0 = {1'b0, cfg_now.pause};
		case (st_phase)
			PH_STOP:      enter_phase(st_spin_left ? PH_SPIN_L : PH_SPIN_R, p0 + 1'b1);
			PH_STOP_BOTH: enter_phase(PH_BACK, p0);
			PH_BACK:      enter_phase(PH_FINAL_R, p0 + 1'b1);
			default: begin
				// decide from this tick's flags
				if (!st_lf && !st_rf) begin
					enter_phase(PH_CRUISE, TICK_W'(1));
				end else if (st_lf && st_rf) begin
					enter_phase(PH_STOP_BOTH, p0);
				end else begin
					st_spin_left = st_rf;
					enter_phase(PH_STOP, p0);
				end
			end
		endcase
	endfunction

	function automatic result_t predict_steer(logic [SAMPLE_W-1:0] ld, ll, rd, rl);
		logic [15:0] ldiff;
		logic [15:0] rdiff;
		result_t     r;
		ldiff = {6'b0, ld} - {6'b0, ll};
		rdiff = {6'b0, rd} - {6'b0, rl};
		st_lf = (ldiff <= {6'b0, cfg_now.threshold});
		st_rf = (rdiff <= {6'b0, cfg_now.threshold});
		if (st_left != 0)
			st_left--;
		// a zero-length phase falls through in the same tick
		while (st_left == 0)
			next_phase();
		r.drive      = st_drive;
		r.left_edge  = st_lf;
		r.right_edge = st_rf;
		r.ph         = st_phase;
		return r;
	endfunction

	function automatic result_t steer(logic l_en, logic [CMP_W-1:0] l_cmp, logic r_en,
			logic [CMP_W-1:0] r_cmp, logic le, logic re, phase_t ph);
		result_t s;
		s.drive.l_en  = l_en;
		s.drive.l_cmp = l_cmp;
		s.drive.r_en  = r_en;
		s.drive.r_cmp = r_cmp;
		s.left_edge   = le;
		s.right_edge  = re;
		s.ph          = ph;
		return s;
	endfunction

	function automatic plan_row_t tick_row(logic [SAMPLE_W-1:0] ld, ll, rd, rl);
		plan_row_t r;
		r.kind  = ROW_TICK;
		r.ld    = ld;
		r.ll    = ll;
		r.rd    = rd;
		r.rl    = rl;
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic plan_row_t tick_known(logic [SAMPLE_W-1:0] ld, ll, rd, rl, result_t w);
		plan_row_t r;
		r       = tick_row(ld, ll, rd, rl);
		r.typed = 1'b1;
		r.want  = w;
		return r;
	endfunction

	function automatic plan_row_t write_row(reg_idx_t idx, logic [DATA_W-1:0] value);
		plan_row_t r;
		r.kind  = ROW_WRITE;
		r.idx   = idx;
		r.value = value;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
		if (want_v != got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want_v, got_v);
		end
	endfunction

	function automatic int pick_gap();
		int roll;
		if ($urandom_range(0, 39) == 0)
			tx_quiet = !tx_quiet;
		roll = $urandom_range(0, 99);
		if (tx_quiet || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_tick(logic [SAMPLE_W-1:0] ld, ll, rd, rl, bit typed, result_t w);
		result_t calc;
		int      gap;
		left_dark  <= ld;
		left_lit   <= ll;
		right_dark <= rd;
		right_lit  <= rl;
		in_valid   <= 1'b1;
		valid_held = 1'b1;
		do @(posedge clk); while (in_stall);
		calc = predict_steer(ld, ll, rd, rl);
		pending_steer.push_back(typed ? w : calc);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		if (valid_held) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
		end
		while (pending_steer.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] kept;
		case (idx)
			REG_THRESHOLD: begin
				cfg_now.threshold = value[THRESH_W-1:0];
				kept = DATA_W'(value[THRESH_W-1:0]);
			end
			REG_PAUSE: begin
				cfg_now.pause = value[PAUSE_W-1:0];
				kept = DATA_W'(value[PAUSE_W-1:0]);
			end
			REG_LEFT_CENTER: begin
				cfg_now.left_center = value[CMP_W-1:0];
				kept = DATA_W'(value[CMP_W-1:0]);
			end
			REG_RIGHT_CENTER: begin
				cfg_now.right_center = value[CMP_W-1:0];
				kept = DATA_W'(value[CMP_W-1:0]);
			end
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// read back what the register kept
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("register readback", kept, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic gen_side(input logic [THRESH_W-1:0] thr, output logic [SAMPLE_W-1:0] dark,
			output logic [SAMPLE_W-1:0] lit);
		int roll;
		int diff;
		int l;
		roll = $urandom_range(0, 99);
		if (roll < 35 && thr != 10'h3FF) begin
			diff = $urandom_range(thr + 1, 1023);
		end else if (roll < 70) begin
			diff = $urandom_range(0, thr);
		end else if (roll < 80) begin
			diff = (thr == 10'h3FF || $urandom_range(0, 1) == 0) ? thr : thr + 1;
		end else if (roll < 90 || roll < 35) begin
			// lit above dark wraps and reads as floor
			l    = $urandom_range(1, 1023);
			lit  = l;
			dark = $urandom_range(0, l - 1);
			return;
		end else begin
			dark = $urandom;
			lit  = $urandom;
			return;
		end
		l    = $urandom_range(0, 1023 - diff);
		lit  = l;
		dark = l + diff;
	endtask

	function automatic logic [CMP_W-1:0] pick_center();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	always @(posedge clk) begin
		if (stall_run > 0) begin
			stall_run--;
		end else begin
			if ($urandom_range(0, 9) == 0)
				rx_quiet = !rx_quiet;
			if (rx_quiet) begin
				out_stall <= 1'b0;
				stall_run = $urandom_range(20, 80);
			end else if ($urandom_range(0, 99) < 40) begin
				out_stall <= 1'b1;
				stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b0;
				stall_run = $urandom_range(0, 4);
			end
		end
	end

	always @(posedge clk) begin
		result_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_steer.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result item arrived with nothing pending");
			end else begin
				due = pending_steer.pop_front();
				check_field("left_enable", due.drive.l_en, left_enable);
				check_field("left_compare", due.drive.l_cmp, left_compare);
				check_field("right_enable", due.drive.r_en, right_enable);
				check_field("right_compare", due.drive.r_cmp, right_compare);
				check_field("left_edge", due.left_edge, left_edge);
				check_field("right_edge", due.right_edge, right_edge);
				check_field("phase_now", due.ph, phase_now);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("edge_avoid_drive_sequencer regression: fail");
		$finish;
	end

	initial begin
		logic [THRESH_W-1:0] thr;
		logic [PAUSE_W-1:0]  pause;
		logic [SAMPLE_W-1:0] ld, ll, rd, rl;
		int                  count;
		result_t             none;

		none    = '0;
		cfg_now = '{threshold: RST_THRESHOLD, pause: RST_PAUSE,
			left_center: RST_LEFT_CENTER, right_center: RST_RIGHT_CENTER};
		st_lf        = 1'b0;
		st_rf        = 1'b0;
		st_spin_left = 1'b0;
		st_drive     = '0;
		enter_phase(PH_CRUISE, TICK_W'(1));

		// reset values, wrap and threshold boundary
		plan.push_back(tick_known(1023, 0, 1023, 0, steer(1, 28, 1, 27, 0, 0, PH_CRUISE)));
		plan.push_back(tick_known(0, 1023, 0, 1023, steer(1, 28, 1, 27, 0, 0, PH_CRUISE)));
		plan.push_back(tick_known(51, 0, 1023, 972, steer(1, 28, 1, 27, 0, 0, PH_CRUISE)));
		plan.push_back(write_row(REG_PAUSE, 32'hFFFF_FF01));
		// left maneuver, then right, then both
		plan.push_back(tick_known(50, 0, 1023, 0, steer(0, 28, 0, 27, 1, 0, PH_STOP)));
		plan.push_back(tick_row(1023, 0, 1023, 0));
		plan.push_back(tick_row(1023, 0, 1023, 0));
		plan.push_back(tick_row(1023, 0, 0, 0));
		plan.push_back(tick_row(1023, 0, 1023, 0));
		plan.push_back(tick_row(1023, 0, 1023, 0));
		plan.push_back(tick_row(0, 0, 1023, 1023));
		plan.push_back(tick_row(1023, 0, 1023, 0));
		plan.push_back(tick_row(1023, 0, 1023, 0));
		plan.push_back(tick_row(1023, 0, 1023, 0));
		plan.push_back(tick_row(1023, 0, 1023, 0));
		// zero pause, zero threshold, compare wrap at both ends
		plan.push_back(write_row(REG_THRESHOLD, 32'hDEAD_FC00));
		plan.push_back(write_row(REG_LEFT_CENTER, 32'h1234_56FF));
		plan.push_back(write_row(REG_RIGHT_CENTER, 32'hFFFF_FF00));
		plan.push_back(write_row(REG_PAUSE, 32'h0000_0100));
		plan.push_back(tick_row(7, 7, 9, 8));
		plan.push_back(tick_row(512, 512, 1023, 1023));
		plan.push_back(tick_row(1023, 0, 1023, 0));
		plan.push_back(tick_row(0, 0, 0, 0));
		plan.push_back(write_row(REG_THRESHOLD, 32'hFFFF_FFFF));
		plan.push_back(tick_row(1023, 0, 0, 1023));
		plan.push_back(tick_row(0, 1023, 1023, 0));
		plan.push_back(tick_row(1023, 1023, 0, 1023));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				wait_idle();
				reg_write(plan[i].idx, plan[i].value);
			end else begin
				send_tick(plan[i].ld, plan[i].ll, plan[i].rd, plan[i].rl,
					plan[i].typed, plan[i].want);
			end
		end

		for (int k = 0; k < 11; k++) begin
			case (k)
				0:       pause = 8'd255;
				1:       pause = 8'd0;
				2:       pause = 8'd1;
				default: pause = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 20)
					: $urandom_range(1, 5);
			endcase
			case (k)
				1: thr = 10'h3FF;
				2: thr = 10'h000;
				default: begin
					case ($urandom_range(0, 5))
						0:       thr = 10'h000;
						1:       thr = 10'h3FF;
						default: thr = $urandom_range(1, 400);
					endcase
				end
			endcase
			wait_idle();
			reg_write(REG_THRESHOLD, ($urandom & ~32'h3FF) | DATA_W'(thr));
			reg_write(REG_PAUSE, ($urandom & ~32'hFF) | DATA_W'(pause));
			reg_write(REG_LEFT_CENTER, ($urandom & ~32'hFF) | DATA_W'(pick_center()));
			reg_write(REG_RIGHT_CENTER, ($urandom & ~32'hFF) | DATA_W'(pick_center()));
			// keep the slowest setting short
			count = (k == 0) ? 40 : 51;
			repeat (count) begin
				gen_side(thr, ld, ll);
				gen_side(thr, rd, rl);
				send_tick(ld, ll, rd, rl, 1'b0, none);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_steer.size() == 0)
			$display("edge_avoid_drive_sequencer regression: pass");
		else
			$display("edge_avoid_drive_sequencer regression: fail");
		$finish;
	end

endmodule
